// File: rtl/core/evs_pkg.sv
// Shared types and constants for the voice envelope with steal.
// No dependencies; every other file in rtl/core depends on this package.
`default_nettype none

package evs_pkg;

  localparam int LEVEL_FRAC_BITS = 24;
  localparam int LEVEL_W         = LEVEL_FRAC_BITS;
  localparam int VEL_W           = 16;
  localparam int PEAK_SHIFT      = LEVEL_FRAC_BITS - VEL_W;
  localparam int LEN_W           = 20;
  localparam int STEAL_W         = 16;
  localparam int NOTE_W          = 8;
  localparam int NN_W            = 7;
  localparam int OP_W            = 3;
  localparam int STAGE_W         = 3;
  localparam int CFG_IDX_W       = 2;
  localparam int DIV_STEPS       = LEVEL_W;
  localparam int CNT_W           = $clog2(DIV_STEPS);

  localparam logic [NOTE_W-1:0]  NO_NOTE     = 8'hFF;
  localparam logic [LEN_W-1:0]   ATTACK_RST  = 20'd441;
  localparam logic [LEN_W-1:0]   RELEASE_RST = 20'd13230;
  localparam logic [STEAL_W-1:0] STEAL_RST   = 16'd220;

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 3'd0,
    OP_NOTE_ON  = 3'd1,
    OP_NOTE_OFF = 3'd2,
    OP_STEAL    = 3'd3,
    OP_SET_HOLD = 3'd4
  } op_t;

  typedef enum logic [STAGE_W-1:0] {
    ST_IDLE    = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_SUSTAIN = 3'd2,
    ST_RELEASE = 3'd3,
    ST_STEAL   = 3'd4
  } stage_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK  = 2'd0,
    CFG_RELEASE = 2'd1,
    CFG_STEAL   = 2'd2
  } cfg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic div_step;
    logic out_load;
  } evs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;
    logic div_last;
  } evs_status_t;

endpackage

`default_nettype wire

// File: rtl/core/evs_if.sv
// Channel interfaces of the voice envelope: item input, result output and
// configuration write. Depends on evs_pkg.
`default_nettype none

interface evs_in_if;
  logic                          valid;
  logic                          ready;
  logic [evs_pkg::OP_W-1:0]      opcode;
  logic [evs_pkg::NN_W-1:0]      note_number;
  logic [evs_pkg::VEL_W-1:0]     velocity;
  logic                          hold;

  modport source (output valid, opcode, note_number, velocity, hold, input ready);
  modport sink   (input valid, opcode, note_number, velocity, hold, output ready);
endinterface

interface evs_out_if;
  logic                          valid;
  logic                          ready;
  logic [evs_pkg::LEVEL_W-1:0]   level;
  logic [evs_pkg::STAGE_W-1:0]   stage_now;
  logic signed [evs_pkg::NOTE_W-1:0] current_note;
  logic                          held;

  modport source (output valid, level, stage_now, current_note, held, input ready);
  modport sink   (input valid, level, stage_now, current_note, held, output ready);
endinterface

interface evs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [evs_pkg::CFG_IDX_W-1:0] index;
  logic [evs_pkg::LEN_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/evs_ctrl.sv
// Sequencer of the voice envelope: accept, execute, divide, deliver.
// Depends on evs_pkg; drives the datapath only through evs_cmd_t.
`default_nettype none

module evs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  evs_pkg::evs_status_t status,
  output evs_pkg::evs_cmd_t    cmd
);
  import evs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_PUT
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = status.need_div ? S_DIV : S_PUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        // hold the result until the output register is free
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/evs_dp.sv
// Datapath of the voice envelope: envelope state, configuration registers,
// radix-2 restoring divider for ramp steps, result register. Depends on evs_pkg.
`default_nettype none

module evs_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  evs_pkg::evs_cmd_t                 cmd,
  output evs_pkg::evs_status_t              status,
  input  logic [evs_pkg::OP_W-1:0]          in_opcode,
  input  logic [evs_pkg::NN_W-1:0]          in_note_number,
  input  logic [evs_pkg::VEL_W-1:0]         in_velocity,
  input  logic                              in_hold,
  input  logic                              cfg_we,
  input  logic [evs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [evs_pkg::LEN_W-1:0]         cfg_data,
  output logic [evs_pkg::LEVEL_W-1:0]       out_level,
  output logic [evs_pkg::STAGE_W-1:0]       out_stage_now,
  output logic signed [evs_pkg::NOTE_W-1:0] out_current_note,
  output logic                              out_held
);
  import evs_pkg::*;

  function automatic logic [LEVEL_W-1:0] vel_to_peak(input logic [VEL_W-1:0] v);
    vel_to_peak = LEVEL_W'(v) << PEAK_SHIFT;
  endfunction

  // configuration
  logic [LEN_W-1:0]   attack_len_r, release_len_r;
  logic [STEAL_W-1:0] steal_len_r;

  // latched item
  op_t               op_r;
  logic [NN_W-1:0]   nn_r;
  logic [VEL_W-1:0]  vel_r;
  logic              hd_r;

  // envelope state
  stage_t             stage_r, stage_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [LEVEL_W-1:0] peak_r, peak_nxt;
  logic [LEVEL_W-1:0] step_r;
  logic [NOTE_W-1:0]  note_r, note_nxt;
  logic [NOTE_W-1:0]  pnote_r, pnote_nxt;
  logic [VEL_W-1:0]   pvel_r, pvel_nxt;
  logic               hold_r, hold_nxt;

  // divider
  logic [LEVEL_W-1:0] quo_r;
  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic [LEN_W-1:0]   dvs_r;
  logic               dvd_nz_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [LEN_W:0]     trial;
  logic               q_bit;
  logic [LEVEL_W-1:0] q_new;

  logic               div_load;
  logic [LEVEL_W-1:0] dvd;
  logic [LEN_W-1:0]   dvs;
  logic [LEVEL_W:0]   attack_sum;
  logic [LEVEL_W-1:0] peak_new;

  always_comb begin
    stage_nxt  = stage_r;
    level_nxt  = level_r;
    peak_nxt   = peak_r;
    note_nxt   = note_r;
    pnote_nxt  = pnote_r;
    pvel_nxt   = pvel_r;
    hold_nxt   = hold_r;
    div_load   = 1'b0;
    dvd        = '0;
    dvs        = attack_len_r;
    peak_new   = vel_to_peak(vel_r);
    attack_sum = {1'b0, level_r} + {1'b0, step_r};
    case (op_r)
      OP_TICK: begin
        case (stage_r)
          ST_ATTACK: begin
            if (attack_sum >= {1'b0, peak_r}) begin
              level_nxt = peak_r;
              stage_nxt = ST_SUSTAIN;
            end else begin
              level_nxt = attack_sum[LEVEL_W-1:0];
            end
          end
          ST_RELEASE, ST_STEAL: begin
            if (step_r >= level_r) begin
              level_nxt = '0;
              if (stage_r == ST_STEAL && pnote_r != NO_NOTE) begin
                // restart the stolen voice with the pending note
                peak_new  = vel_to_peak(pvel_r);
                note_nxt  = pnote_r;
                peak_nxt  = peak_new;
                stage_nxt = ST_ATTACK;
                hold_nxt  = 1'b0;
                pnote_nxt = NO_NOTE;
                div_load  = 1'b1;
                dvd       = peak_new;
                dvs       = attack_len_r;
              end else begin
                stage_nxt = ST_IDLE;
                note_nxt  = NO_NOTE;
              end
            end else begin
              level_nxt = level_r - step_r;
            end
          end
          default: ;
        endcase
      end
      OP_NOTE_ON: begin
        level_nxt = '0;
        note_nxt  = {1'b0, nn_r};
        peak_nxt  = peak_new;
        stage_nxt = ST_ATTACK;
        hold_nxt  = 1'b0;
        pnote_nxt = NO_NOTE;
        div_load  = 1'b1;
        dvd       = peak_new;
        dvs       = attack_len_r;
      end
      OP_NOTE_OFF: begin
        if (stage_r == ST_ATTACK || stage_r == ST_SUSTAIN) begin
          hold_nxt  = 1'b0;
          stage_nxt = ST_RELEASE;
          div_load  = 1'b1;
          dvd       = level_r;
          dvs       = release_len_r;
        end
      end
      OP_STEAL: begin
        pnote_nxt = {1'b0, nn_r};
        pvel_nxt  = vel_r;
        hold_nxt  = 1'b0;
        stage_nxt = ST_STEAL;
        div_load  = 1'b1;
        dvd       = (level_r != '0) ? level_r : LEVEL_W'(1);
        dvs       = LEN_W'(steal_len_r);
      end
      OP_SET_HOLD: hold_nxt = hd_r;
      default: ;
    endcase
  end

  // one quotient bit per cycle
  assign trial   = {rem_r, quo_r[LEVEL_W-1]};
  assign q_bit   = (trial >= {1'b0, dvs_r});
  assign rem_nxt = q_bit ? LEN_W'(trial - {1'b0, dvs_r}) : LEN_W'(trial);
  assign q_new   = {quo_r[LEVEL_W-2:0], q_bit};

  assign status.need_div = div_load;
  assign status.div_last = (cnt_r == CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_len_r  <= ATTACK_RST;
      release_len_r <= RELEASE_RST;
      steal_len_r   <= STEAL_RST;
      stage_r       <= ST_IDLE;
      level_r       <= '0;
      peak_r        <= '0;
      step_r        <= '0;
      note_r        <= NO_NOTE;
      pnote_r       <= NO_NOTE;
      pvel_r        <= '0;
      hold_r        <= 1'b0;
      cnt_r         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ATTACK:  attack_len_r  <= cfg_data;
          CFG_RELEASE: release_len_r <= cfg_data;
          CFG_STEAL:   steal_len_r   <= cfg_data[STEAL_W-1:0];
          default: ;
        endcase
      end
      if (cmd.exec) begin
        stage_r <= stage_nxt;
        level_r <= level_nxt;
        peak_r  <= peak_nxt;
        note_r  <= note_nxt;
        pnote_r <= pnote_nxt;
        pvel_r  <= pvel_nxt;
        hold_r  <= hold_nxt;
        cnt_r   <= '0;
      end
      if (cmd.div_step) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (status.div_last) begin
          // a nonzero dividend never yields a zero step
          step_r <= (q_new == '0 && dvd_nz_r) ? LEVEL_W'(1) : q_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= op_t'(in_opcode);
      nn_r  <= in_note_number;
      vel_r <= in_velocity;
      hd_r  <= in_hold;
    end
    if (cmd.exec && div_load) begin
      quo_r    <= dvd;
      rem_r    <= '0;
      dvs_r    <= (dvs == '0) ? LEN_W'(1) : dvs;
      dvd_nz_r <= (dvd != '0);
    end else if (cmd.div_step) begin
      quo_r <= q_new;
      rem_r <= rem_nxt;
    end
    if (cmd.out_load) begin
      out_level        <= level_r;
      out_stage_now    <= stage_r;
      out_current_note <= $signed(note_r);
      out_held         <= hold_r;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/voice_envelope_with_steal_unit.sv
// Top level of the voice envelope with steal: sequencer plus datapath.
// Depends on evs_pkg, evs_if, evs_ctrl and evs_dp.
//
// Usage:
//   in_ch  carries one command beat: tick, note on, note off, steal, set hold.
//   out_ch returns exactly one result beat per command: level (Q0.24),
//          stage, current note (-1 when idle) and the hold flag.
//   cfg_ch writes the attack, release and steal lengths; it is always ready.
//          Write it only while no command is in flight.
// Timing:
//   A command that sets up a ramp (note on, note off that acts, steal, a tick
//   that restarts a stolen voice) runs the shared serial divider, one quotient
//   bit per cycle until all 24 quotient bits are formed, then loads the result.
//   Other commands go from execution straight to loading the result. A new
//   beat is taken only once the previous result has been loaded.
//   A finished result sits in the output register; the next command is
//   accepted and computed meanwhile and waits in its last step while the
//   receiver stalls.
// Reset: synchronous, active low; voice idle, lengths 441, 13230 and 220.
`default_nettype none

module voice_envelope_with_steal_unit (
  input  logic      clk,
  input  logic      rst_n,
  evs_in_if.sink    in_ch,
  evs_out_if.source out_ch,
  evs_cfg_if.sink   cfg_ch
);
  import evs_pkg::*;

  evs_cmd_t    cmd;
  evs_status_t status;

  assign cfg_ch.ready = 1'b1;

  evs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  evs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_opcode        (in_ch.opcode),
    .in_note_number   (in_ch.note_number),
    .in_velocity      (in_ch.velocity),
    .in_hold          (in_ch.hold),
    .cfg_we           (cfg_ch.valid),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .out_level        (out_ch.level),
    .out_stage_now    (out_ch.stage_now),
    .out_current_note (out_ch.current_note),
    .out_held         (out_ch.held)
  );

`ifndef SYNTHESIS
  // one command at a time: no beat right after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while a command is in flight");

  // never overwrite a result the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten before delivery");

  // divider stops after its last quotient bit
  a_div_stops: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step && status.div_last |=> !cmd.div_step && !in_ch.ready)
    else $error("divider kept running past its last step");
`endif

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking bench for voice_envelope_with_steal_unit: random and directed
// commands against a cycle-free envelope predictor. Uses evs_pkg and evs_if.
// Command and result channels are stalled in random bursts.
`default_nettype none

module tb;
  import evs_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED5 = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED7 = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [NN_W-1:0]  nn;
    logic [VEL_W-1:0] vel;
    logic             hd;
  } voice_cmd_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [STAGE_W-1:0] stage;
    logic [NOTE_W-1:0]  note;
    logic               held;
  } voice_result_t;

  logic clk = 1'b0;
  logic rst_n;

  evs_in_if  in_ch();
  evs_out_if out_ch();
  evs_cfg_if cfg_ch();

  voice_envelope_with_steal_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // envelope mirror
  stage_t            env_stage;
  logic [31:0]       env_level, env_peak, env_step;
  logic [NOTE_W-1:0] env_note, pend_note;
  logic [VEL_W-1:0]  pend_vel;
  logic              env_hold;
  logic [LEN_W-1:0]  attack_len, release_len;
  logic [STEAL_W-1:0] steal_len;

  voice_cmd_t    cmd_q[$];
  voice_result_t expected_q[$];

  int  n_errors, n_results, n_queued, n_cfg;
  int  n_restarts, n_to_idle, n_to_sustain;
  int  op_count[8];
  bit  idle_on;
  bit  in_pending;
  int  in_gap, in_calm, out_stall, out_calm;

  function automatic logic [31:0] ramp_div(input logic [31:0] amount, input logic [31:0] len);
    logic [31:0] d, s;
    d = (len == 0) ? 32'd1 : len;
    s = amount / d;
    if (amount != 0 && s == 0) s = 32'd1;
    return s;
  endfunction

  function automatic void start_voice(input logic [NOTE_W-1:0] note, input logic [VEL_W-1:0] vel);
    env_note  = note;
    env_peak  = 32'(vel) << PEAK_SHIFT;
    env_step  = ramp_div(env_peak, 32'(attack_len));
    env_stage = ST_ATTACK;
    env_hold  = 1'b0;
    pend_note = NO_NOTE;
  endfunction

  function automatic void advance_tick();
    case (env_stage)
      ST_ATTACK: begin
        env_level = env_level + env_step;
        if (env_level >= env_peak) begin
          env_level = env_peak;
          env_stage = ST_SUSTAIN;
          n_to_sustain++;
        end
      end
      ST_RELEASE, ST_STEAL: begin
        if (env_step >= env_level) begin
          env_level = 0;
          if (env_stage == ST_STEAL && pend_note != NO_NOTE) begin
            start_voice(pend_note, pend_vel);
            n_restarts++;
          end else begin
            env_stage = ST_IDLE;
            env_note  = NO_NOTE;
            n_to_idle++;
          end
        end else begin
          env_level = env_level - env_step;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic voice_result_t predict_envelope(input voice_cmd_t c);
    voice_result_t r;
    op_count[c.op]++;
    case (c.op)
      OP_TICK: advance_tick();
      OP_NOTE_ON: begin
        env_level = 0;
        start_voice({1'b0, c.nn}, c.vel);
      end
      OP_NOTE_OFF: begin
        if (env_stage == ST_ATTACK || env_stage == ST_SUSTAIN) begin
          env_hold  = 1'b0;
          env_stage = ST_RELEASE;
          env_step  = ramp_div(env_level, 32'(release_len));
        end
      end
      OP_STEAL: begin
        pend_note = {1'b0, c.nn};
        pend_vel  = c.vel;
        env_hold  = 1'b0;
        env_stage = ST_STEAL;
        env_step  = ramp_div((env_level != 0) ? env_level : 32'd1, 32'(steal_len));
      end
      OP_SET_HOLD: env_hold = c.hd;
      default: ;
    endcase
    r.level = env_level[LEVEL_W-1:0];
    r.stage = env_stage;
    r.note  = env_note;
    r.held  = env_hold;
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [23:0] want,
                                      input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, what, want, got);
      n_errors++;
    end
  endfunction

  // accept command beats, predict, and check result beats
  always @(posedge clk) begin
    voice_cmd_t    c;
    voice_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        c.op  = in_ch.opcode;
        c.nn  = in_ch.note_number;
        c.vel = in_ch.velocity;
        c.hd  = in_ch.hold;
        void'(cmd_q.pop_front());
        in_pending = 1'b0;
        expected_q.push_back(predict_envelope(c));
      end
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat, level %h stage %0d note %h held %b", $time,
                   out_ch.level, out_ch.stage_now, out_ch.current_note, out_ch.held);
          n_errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("level", want.level, out_ch.level);
          check_field("stage_now", {21'd0, want.stage}, {21'd0, out_ch.stage_now});
          check_field("current_note", {16'd0, want.note}, {16'd0, out_ch.current_note});
          check_field("held", {23'd0, want.held}, {23'd0, out_ch.held});
        end
      end
    end
  end

  // command driver: hold a beat until taken, gaps only between beats
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_pending) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (idle_on && in_calm == 0 && $urandom_range(0, 5) == 0) begin
        in_gap  = $urandom_range(1, 18) - 1;
        in_calm = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 6);
        in_ch.valid <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        if (in_calm > 0) in_calm--;
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= cmd_q[0].op;
        in_ch.note_number <= cmd_q[0].nn;
        in_ch.velocity    <= cmd_q[0].vel;
        in_ch.hold        <= cmd_q[0].hd;
        in_pending = 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver with stall bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 1'b0;
    end else if (idle_on && out_calm == 0 && $urandom_range(0, 7) == 0) begin
      out_stall = $urandom_range(1, 18) - 1;
      out_calm  = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 6);
      out_ch.ready <= 1'b0;
    end else begin
      if (out_calm > 0) out_calm--;
      out_ch.ready <= 1'b1;
    end
  end

  function automatic logic [VEL_W-1:0] rand_vel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return VEL_W'($urandom_range(1, 255));
      default: return VEL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic add_cmd(input logic [OP_W-1:0] op, input logic [NN_W-1:0] nn,
                         input logic [VEL_W-1:0] vel, input logic hd);
    voice_cmd_t c;
    c.op  = op;
    c.nn  = nn;
    c.vel = vel;
    c.hd  = hd;
    cmd_q.push_back(c);
    n_queued++;
  endtask

  task automatic add_ticks(input int n);
    repeat (n) add_cmd(OP_TICK, NN_W'($urandom_range(0, 127)), rand_vel(), 1'($urandom));
  endtask

  // len + 2 ticks, capped at 40, to finish a ramp of this length, or fewer to cut it short
  function automatic int tick_span(input int len);
    int c;
    c = (len > 38) ? 40 : len + 2;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, c) : c;
  endfunction

  task automatic gen_random(input int target);
    int stop_at;
    stop_at = n_queued + target;
    while (n_queued < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          add_cmd(OP_NOTE_ON, NN_W'($urandom_range(0, 127)), rand_vel(), 1'($urandom));
          add_ticks(tick_span(attack_len));
          if ($urandom_range(0, 2) == 0)
            add_cmd(OP_SET_HOLD, NN_W'($urandom), rand_vel(), 1'($urandom));
          if ($urandom_range(0, 4) != 0)
            add_cmd(OP_NOTE_OFF, NN_W'($urandom), rand_vel(), 1'($urandom));
          add_ticks(tick_span(release_len));
        end
        4, 5, 6: begin
          add_cmd(OP_STEAL, NN_W'($urandom_range(0, 127)), rand_vel(), 1'($urandom));
          add_ticks(tick_span(steal_len));
          add_ticks(tick_span(attack_len));
          if ($urandom_range(0, 1) == 0) begin
            add_cmd(OP_NOTE_OFF, NN_W'($urandom), rand_vel(), 1'($urandom));
            add_ticks(tick_span(release_len));
          end
        end
        7: begin
          // interrupt ramps midway with note on, note off and steal
          repeat ($urandom_range(2, 6)) begin
            add_cmd(OP_W'($urandom_range(1, 3)), NN_W'($urandom), rand_vel(), 1'($urandom));
            add_ticks($urandom_range(0, 4));
          end
        end
        default: begin
          repeat ($urandom_range(1, 6))
            add_cmd(OP_W'($urandom_range(0, 7)), NN_W'($urandom), rand_vel(), 1'($urandom));
        end
      endcase
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [LEN_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_ATTACK:  attack_len  = val;
      CFG_RELEASE: release_len = val;
      CFG_STEAL:   steal_len   = val[STEAL_W-1:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_lengths(input logic [LEN_W-1:0] a, input logic [LEN_W-1:0] r,
                               input logic [LEN_W-1:0] s);
    write_reg(CFG_ATTACK, a);
    write_reg(CFG_RELEASE, r);
    write_reg(CFG_STEAL, s);
  endtask

  // hold off until every result is in, then let the divider settle
  task automatic wait_idle();
    while (cmd_q.size() != 0 || in_pending || expected_q.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
  endtask

  initial begin
    #4800000;
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = '0;
    in_ch.note_number  = '0;
    in_ch.velocity     = '0;
    in_ch.hold         = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    idle_on            = 1'b0;
    in_pending         = 1'b0;
    env_stage   = ST_IDLE;
    env_level   = 0;
    env_peak    = 0;
    env_step    = 0;
    env_note    = NO_NOTE;
    pend_note   = NO_NOTE;
    pend_vel    = '0;
    env_hold    = 1'b0;
    attack_len  = ATTACK_RST;
    release_len = RELEASE_RST;
    steal_len   = STEAL_RST;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset lengths: ignored commands, steal from idle, note off in idle, attack, release and steal
    add_cmd(OP_TICK, 7'd0, 16'h0000, 1'b0);
    add_cmd(OP_NOTE_OFF, 7'd0, 16'h0000, 1'b0);
    add_cmd(OP_SET_HOLD, 7'd0, 16'h0000, 1'b1);
    add_cmd(OP_NOTE_OFF, 7'd0, 16'h0000, 1'b0);
    add_cmd(OP_UNUSED5, 7'd127, 16'hFFFF, 1'b1);
    add_cmd(OP_UNUSED7, 7'd0, 16'h0000, 1'b0);
    add_cmd(OP_STEAL, 7'd127, 16'hFFFF, 1'b0);
    add_cmd(OP_TICK, 7'd0, 16'h0000, 1'b0);
    add_cmd(OP_TICK, 7'd0, 16'h0000, 1'b0);
    add_cmd(OP_SET_HOLD, 7'd0, 16'h0000, 1'b1);
    add_cmd(OP_NOTE_OFF, 7'd0, 16'h0000, 1'b0);
    add_cmd(OP_NOTE_OFF, 7'd0, 16'h0000, 1'b0);
    add_cmd(OP_STEAL, 7'd0, 16'h0000, 1'b0);
    add_cmd(OP_NOTE_OFF, 7'd0, 16'h0000, 1'b0);
    add_cmd(OP_UNUSED6, 7'd127, 16'hFFFF, 1'b1);
    add_cmd(OP_SET_HOLD, 7'd0, 16'h0000, 1'b0);
    wait_idle();

    // zero attack length acts as one; zero velocity; release from level zero
    write_lengths(20'd0, 20'd1, 20'd1);
    add_cmd(OP_NOTE_ON, 7'd0, 16'h0000, 1'b0);
    add_cmd(OP_TICK, 7'd0, 16'h0000, 1'b0);
    add_cmd(OP_NOTE_OFF, 7'd0, 16'h0000, 1'b0);
    add_cmd(OP_TICK, 7'd0, 16'h0000, 1'b0);
    add_cmd(OP_NOTE_ON, 7'd127, 16'hFFFF, 1'b1);
    add_cmd(OP_TICK, 7'd0, 16'h0000, 1'b0);
    add_cmd(OP_SET_HOLD, 7'd0, 16'h0000, 1'b1);
    add_cmd(OP_STEAL, 7'd64, 16'h8000, 1'b0);
    add_cmd(OP_TICK, 7'd0, 16'h0000, 1'b0);
    add_cmd(OP_TICK, 7'd0, 16'h0000, 1'b0);
    add_cmd(OP_NOTE_OFF, 7'd0, 16'h0000, 1'b0);
    add_cmd(OP_TICK, 7'd0, 16'h0000, 1'b0);
    wait_idle();

    idle_on = 1'b1;
    write_lengths(20'd3, 20'd5, 20'd2);
    gen_random(260);
    wait_idle();

    write_lengths(LEN_W'($urandom_range(1, 64)), LEN_W'($urandom_range(1, 64)),
                  LEN_W'($urandom_range(1, 32)));
    gen_random(140);
    wait_idle();
    gen_random(140);
    wait_idle();

    // longest ramps; upper data bits of the steal write are dropped
    write_lengths(20'hFFFFF, 20'hFFFFF, {4'($urandom_range(1, 15)), 16'hFFFF});
    gen_random(200);
    wait_idle();

    write_lengths(20'd1, 20'd0, 20'd0);
    gen_random(200);
    wait_idle();

    idle_on = 1'b0;
    write_lengths(LEN_W'($urandom_range(1, 24)), LEN_W'($urandom_range(1, 24)),
                  LEN_W'($urandom_range(1, 24)));
    gen_random(260);
    wait_idle();

    $display("Covered %0d commands (%0d ticks, %0d note on, %0d note off, %0d steal, %0d hold,",
             n_queued, op_count[0], op_count[1], op_count[2], op_count[3], op_count[4]);
    $display("  %0d unused) under %0d register writes; %0d results, %0d sustains, %0d idles, %0d restarts.",
             op_count[5] + op_count[6] + op_count[7], n_cfg, n_results, n_to_sustain, n_to_idle,
             n_restarts);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: voice_envelope_with_steal_unit.f
rtl/core/evs_pkg.sv
rtl/core/evs_if.sv
rtl/core/evs_ctrl.sv
rtl/core/evs_dp.sv
rtl/core/voice_envelope_with_steal_unit.sv
test/tb.sv
